// ===== rtl/bspc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_pkg
// Shared types and constants for the bitmap store with popcount.
// ----------------------------------------------------------------------------
package bspc_pkg;

  // Capacity of the store in 64-bit words.
  localparam int NUM_WORDS = 64;

  localparam int WORD_W     = 64;
  localparam int BIT_POS_W  = $clog2(WORD_W);
  localparam int ACTION_W   = 3;
  localparam int BIT_IDX_W  = 12;
  localparam int WORD_SEL_W = BIT_IDX_W - BIT_POS_W;
  localparam int COUNT_W    = 13;
  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WALK_W     = $clog2(NUM_WORDS + 1);
  localparam int POP_W      = $clog2(WORD_W + 1);

  localparam int IN_DATA_W  = ((ACTION_W + BIT_IDX_W + 7) / 8) * 8;
  localparam int RES_W      = 1 + COUNT_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] SWAR_M1 = 64'h5555555555555555;
  localparam logic [WORD_W-1:0] SWAR_M2 = 64'h3333333333333333;
  localparam logic [WORD_W-1:0] SWAR_M4 = 64'h0f0f0f0f0f0f0f0f;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TEST       = 3'd0,
    ACT_SET        = 3'd1,
    ACT_CLEAR      = 3'd2,
    ACT_TEST_CLEAR = 3'd3,
    ACT_COUNT      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  // Result item, was_set in the lowest bit.
  typedef struct packed {
    logic [COUNT_W-1:0] set_count;
    logic               was_set;
  } result_t;

endpackage : bspc_pkg
`default_nettype wire

// ===== rtl/bspc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bspc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : bspc_ram
`default_nettype wire

// ===== rtl/bitmap_store_with_popcount_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_store_with_popcount_unit
// Bitmap of NUM_WORDS x 64 bits with bit test/set/clear and a full popcount.
// ----------------------------------------------------------------------------
// Test, set, clear and test-then-clear run as a word read-modify-write on one
// RAM and sustain one transaction per cycle while the output buffer has room;
// a write from the previous cycle is forwarded to a read of the same word. A
// count walks the words through the single RAM read port, one word per cycle,
// and no new transaction is accepted until it is done. The store reads as all
// zeros after reset through per-word valid flops, so there is no clearing pass.
// Unused action codes return zeros and change nothing. Results queue in a
// two-entry output buffer, so input is taken while a result waits.
module bitmap_store_with_popcount_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: [2:0] action, [14:3] bit_index, [15] zero
  input  wire logic [bspc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: [0] was_set, [13:1] set_count, [15:14] zero
  output logic      [bspc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int AW = bspc_pkg::WORD_AW;

  function automatic logic [bspc_pkg::POP_W-1:0] word_popcount(
    input logic [bspc_pkg::WORD_W-1:0] v
  );
    logic [bspc_pkg::WORD_W-1:0] s1, s2, s3;
    logic [bspc_pkg::POP_W-1:0]  acc;
    s1  = v - ((v >> 1) & bspc_pkg::SWAR_M1);
    s2  = (s1 & bspc_pkg::SWAR_M2) + ((s1 >> 2) & bspc_pkg::SWAR_M2);
    s3  = (s2 + (s2 >> 4)) & bspc_pkg::SWAR_M4;
    acc = '0;
    for (int b = 0; b < bspc_pkg::WORD_W / 8; b++) begin
      acc = acc + bspc_pkg::POP_W'(s3[b*8 +: 4]);
    end
    return acc;
  endfunction

  // Input decode
  bspc_pkg::action_e                   in_act;
  logic [bspc_pkg::BIT_IDX_W-1:0]      in_idx;
  logic [bspc_pkg::WORD_SEL_W-1:0]     in_word;
  logic                                in_accept;

  assign in_act    = bspc_pkg::action_e'(s_axis_tdata[bspc_pkg::ACTION_W-1:0]);
  assign in_idx    = s_axis_tdata[bspc_pkg::ACTION_W +: bspc_pkg::BIT_IDX_W];
  assign in_word   = in_idx[bspc_pkg::BIT_IDX_W-1:bspc_pkg::BIT_POS_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Control state
  bspc_pkg::state_e state_q, state_d;
  logic [bspc_pkg::WALK_W-1:0] walk_q, walk_d;
  logic                        rd_v_q, rd_v_d;
  logic                        pc_v_q;
  logic [bspc_pkg::POP_W-1:0]  pc_q;
  logic [bspc_pkg::COUNT_W-1:0] sum_q;
  logic                        sum_clr;
  logic                        cnt_push;

  // Read-modify-write stage
  logic                         s1_v_q;
  bspc_pkg::action_e            s1_act_q;
  logic [bspc_pkg::BIT_POS_W-1:0] s1_pos_q;
  logic                         s1_inr_q;
  logic [AW-1:0]                rd_addr_q;

  // Last write, for forwarding
  logic                         wr_v_q;
  logic [AW-1:0]                wr_addr_q;
  logic [bspc_pkg::WORD_W-1:0]  wr_data_q;

  localparam int NUM_VALID_W = bspc_pkg::NUM_WORDS;
  logic [NUM_VALID_W-1:0]       valid_q;

  // RAM
  logic [AW-1:0]                raddr;
  logic [bspc_pkg::WORD_W-1:0]  rdata;
  logic                         we;
  logic [bspc_pkg::WORD_W-1:0]  wdata;

  bspc_ram #(
    .WIDTH (bspc_pkg::WORD_W),
    .DEPTH (bspc_pkg::NUM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (rd_addr_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr = (state_q == bspc_pkg::ST_WALK) ? walk_q[AW-1:0] : AW'(in_word);

  // Word as stored: unwritten words read as zero
  logic [bspc_pkg::WORD_W-1:0] mem_word;
  logic [bspc_pkg::WORD_W-1:0] cur_word;
  assign mem_word = valid_q[rd_addr_q] ? rdata : '0;
  assign cur_word = (wr_v_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : mem_word;

  logic old_bit;
  logic s1_wr;
  assign old_bit = cur_word[s1_pos_q];

  always_comb begin
    s1_wr = 1'b0;
    wdata = cur_word;
    case (s1_act_q)
      bspc_pkg::ACT_SET: begin
        s1_wr = 1'b1;
        wdata = cur_word | (bspc_pkg::WORD_W'(1) << s1_pos_q);
      end
      bspc_pkg::ACT_CLEAR, bspc_pkg::ACT_TEST_CLEAR: begin
        s1_wr = 1'b1;
        wdata = cur_word & ~(bspc_pkg::WORD_W'(1) << s1_pos_q);
      end
      default: begin
        s1_wr = 1'b0;
      end
    endcase
  end

  assign we = s1_v_q && s1_inr_q && s1_wr;

  bspc_pkg::result_t s1_res;
  always_comb begin
    s1_res           = '0;
    s1_res.was_set   = 1'b0;
    if (s1_inr_q && (s1_act_q == bspc_pkg::ACT_TEST || s1_act_q == bspc_pkg::ACT_SET ||
                     s1_act_q == bspc_pkg::ACT_CLEAR ||
                     s1_act_q == bspc_pkg::ACT_TEST_CLEAR)) begin
      s1_res.was_set = old_bit;
    end
  end

  // Output buffer, two entries
  bspc_pkg::result_t fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fifo_cnt_q;
  logic       push, pop;
  bspc_pkg::result_t push_res;
  logic [1:0] occ_next;

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign push     = s1_v_q || cnt_push;
  assign push_res = cnt_push ? bspc_pkg::result_t'{set_count: sum_q, was_set: 1'b0} : s1_res;
  assign occ_next = 2'(fifo_cnt_q + {1'b0, s1_v_q} - {1'b0, pop});

  assign m_axis_tvalid = (fifo_cnt_q != 2'd0);
  assign m_axis_tdata  = bspc_pkg::OUT_DATA_W'(fifo_q[rd_ptr_q]);
  assign s_axis_tready = (state_q == bspc_pkg::ST_IDLE) && (occ_next < 2'd2);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fifo_cnt_q <= 2'(fifo_cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  // Count sequencer
  always_comb begin
    state_d  = state_q;
    walk_d   = walk_q;
    rd_v_d   = 1'b0;
    sum_clr  = 1'b0;
    cnt_push = 1'b0;
    unique case (state_q)
      bspc_pkg::ST_IDLE: begin
        if (in_accept && in_act == bspc_pkg::ACT_COUNT) begin
          state_d = bspc_pkg::ST_WALK;
          walk_d  = '0;
          sum_clr = 1'b1;
        end
      end
      bspc_pkg::ST_WALK: begin
        rd_v_d = 1'b1;
        walk_d = walk_q + bspc_pkg::WALK_W'(1);
        if (walk_q == bspc_pkg::WALK_W'(bspc_pkg::NUM_WORDS - 1)) begin
          state_d = bspc_pkg::ST_DRAIN;
        end
      end
      bspc_pkg::ST_DRAIN: begin
        // wait for the last word to reach the accumulator and for buffer room
        if (!rd_v_q && !pc_v_q && (fifo_cnt_q != 2'd2 || pop)) begin
          cnt_push = 1'b1;
          state_d  = bspc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bspc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bspc_pkg::ST_IDLE;
      walk_q  <= '0;
      rd_v_q  <= 1'b0;
      pc_v_q  <= 1'b0;
      sum_q   <= '0;
      s1_v_q  <= 1'b0;
      wr_v_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      rd_v_q  <= rd_v_d;
      pc_v_q  <= rd_v_q;
      if (sum_clr) begin
        sum_q <= '0;
      end else if (pc_v_q) begin
        sum_q <= sum_q + bspc_pkg::COUNT_W'(pc_q);
      end
      s1_v_q <= in_accept && (in_act != bspc_pkg::ACT_COUNT);
      wr_v_q <= we;
      if (we) begin
        valid_q[rd_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
    pc_q      <= word_popcount(mem_word);
    if (in_accept) begin
      s1_act_q <= in_act;
      s1_pos_q <= in_idx[bspc_pkg::BIT_POS_W-1:0];
      s1_inr_q <= (32'(in_word) < bspc_pkg::NUM_WORDS);
    end
    if (we) begin
      wr_addr_q <= rd_addr_q;
      wr_data_q <= wdata;
    end
  end

endmodule : bitmap_store_with_popcount_unit
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitmap_store_with_popcount_unit. A queue of bit
// requests (directed corner cases, then random traffic focused on a few hot
// words) feeds a stream driver. A shadow bitmap predicts was_set and the
// popcount for every accepted transaction, and a monitor compares each
// returned result in order. Four flow-control phases vary source gaps and
// sink back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import bspc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 300;

  typedef struct {
    logic [ACTION_W-1:0]  action;
    logic [BIT_IDX_W-1:0] bit_index;
  } bit_request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bitmap_store_with_popcount_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow copy of the store and bookkeeping
  logic [WORD_W-1:0] shadow_words [NUM_WORDS];
  bit_request_t      pending_requests [$];
  result_t           expected_results [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int n_directed     = 0;
  int n_random       = 0;
  int n_accepted     = 0;
  int n_counts       = 0;
  int n_checked      = 0;
  int n_errors       = 0;
  int idle_cycles    = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    foreach (shadow_words[w]) shadow_words[w] = '0;
  end

  // Applies one request to the shadow bitmap and returns the result it gives.
  function automatic result_t apply_request(logic [ACTION_W-1:0] act,
                                            logic [BIT_IDX_W-1:0] idx);
    result_t r;
    int      word;
    int      pos;
    int      total;
    r     = '0;
    word  = int'(idx >> 6);
    pos   = int'(idx[5:0]);
    total = 0;
    if (act == ACT_COUNT) begin
      n_counts++;
      foreach (shadow_words[w]) total += $countones(shadow_words[w]);
      r.set_count = total[COUNT_W-1:0];
    end else if (act <= ACT_TEST_CLEAR && word < NUM_WORDS) begin
      r.was_set = shadow_words[word][pos];
      case (act)
        ACT_SET:                  shadow_words[word][pos] = 1'b1;
        ACT_CLEAR, ACT_TEST_CLEAR: shadow_words[word][pos] = 1'b0;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Random request; set_pct biases toward sets to fill the store.
  function automatic bit_request_t random_request(int set_pct);
    bit_request_t r;
    int           roll;
    int           hot_word;
    roll = $urandom_range(99);
    if (roll < 4) begin
      r.action = ACT_COUNT;
    end else if (roll < 6) begin
      r.action = ACTION_W'($urandom_range(7, 5));
    end else if ($urandom_range(99) < set_pct) begin
      r.action = ACT_SET;
    end else begin
      case ($urandom_range(2))
        0:       r.action = ACT_TEST;
        1:       r.action = ACT_CLEAR;
        default: r.action = ACT_TEST_CLEAR;
      endcase
    end
    // half the traffic hits a small hot set so tests see set bits and
    // back-to-back writes land on the same word
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(2))
        0:       hot_word = 0;
        1:       hot_word = 1;
        default: hot_word = NUM_WORDS - 1;
      endcase
      r.bit_index = BIT_IDX_W'(hot_word * 64 + $urandom_range(7) * 9);
    end else begin
      r.bit_index = BIT_IDX_W'($urandom_range(4095));
    end
    return r;
  endfunction

  task automatic push_directed(logic [ACTION_W-1:0] act, int idx);
    bit_request_t r;
    r.action    = act;
    r.bit_index = BIT_IDX_W'(idx);
    pending_requests = {pending_requests, r};
    n_directed++;
  endtask

  task automatic push_random(int n, int set_pct);
    bit_request_t r;
    repeat (n) begin
      r = random_request(set_pct);
      pending_requests = {pending_requests, r};
      n_random++;
    end
  endtask

  // Sender holds back until the queue is empty and all results are back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
  endtask

  task automatic note_mismatch(string field, int want, int got);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch on %s, result %0d: expected %0d, got %0d",
               field, n_checked, want, got);
  endtask

  // Driver: predict on acceptance, then present the next request or idle.
  always @(posedge clk_i) begin : drive_requests
    bit_request_t req;
    result_t      pred;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = apply_request(s_axis_tdata[ACTION_W-1:0],
                             s_axis_tdata[ACTION_W +: BIT_IDX_W]);
        expected_results = {expected_results, pred};
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'({req.bit_index, req.action});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each returned transaction with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: was_set %0d set_count %0d",
                     got.was_set, got.set_count);
        end else begin
          want = expected_results.pop_front();
          if (got.was_set !== want.was_set)
            note_mismatch("was_set", want.was_set, got.was_set);
          if (got.set_count !== want.set_count)
            note_mismatch("set_count", want.set_count, got.set_count);
          n_checked++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners: both ends of the index range, word boundaries,
    // repeated set, double clear, unused codes, counts between the steps
    push_directed(ACT_TEST, 0);
    push_directed(ACT_SET, 0);
    push_directed(ACT_TEST, 0);
    push_directed(ACT_SET, 4095);
    push_directed(ACT_SET, 4095);
    push_directed(ACT_COUNT, 0);
    push_directed(ACT_TEST_CLEAR, 4095);
    push_directed(ACT_TEST, 4095);
    push_directed(ACT_SET, 63);
    push_directed(ACT_SET, 64);
    push_directed(ACT_COUNT, 4095);
    push_directed(ACT_CLEAR, 63);
    push_directed(ACT_CLEAR, 63);
    push_directed(ACT_CLEAR, 0);
    push_directed(ACT_COUNT, 12'haaa);
    push_directed(ACTION_W'(5), 4095);
    push_directed(ACTION_W'(6), 0);
    push_directed(ACTION_W'(7), 12'haaa);
    push_directed(ACT_TEST, 12'h555);
    push_directed(ACT_SET, 12'h555);
    push_directed(ACT_TEST_CLEAR, 12'h555);
    push_directed(ACT_TEST_CLEAR, 12'h555);
    push_directed(ACT_COUNT, 0);
    wait_drained();

    // no flow control
    src_idle_pct = 0;  sink_stall_pct = 0;
    push_random(RANDOM_PER_PHASE, 40);
    wait_drained();

    // sparse source, set-heavy to push the count up
    src_idle_pct = 60; sink_stall_pct = 0;
    push_random(RANDOM_PER_PHASE, 80);
    wait_drained();

    // heavy back-pressure
    src_idle_pct = 0;  sink_stall_pct = 60;
    push_random(RANDOM_PER_PHASE, 30);
    wait_drained();

    // light gaps on both sides
    src_idle_pct = 8;  sink_stall_pct = 8;
    push_random(RANDOM_PER_PHASE, 40);
    wait_drained();

    // catch any stray result
    repeat (NUM_WORDS + 16) @(posedge clk_i);
    if (expected_results.size() > 0) begin
      n_errors++;
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d requests (%0d directed, %0d random) incl. %0d counts,",
             n_accepted, n_directed, n_random, n_counts);
    $display("over four flow-control phases; %0d results checked, %0d errors.",
             n_checked, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
